### src/srf_pkg.sv
`timescale 1ns / 1ps
// Package for the stepped crossfade ramp: default sizes, register indexes,
// and the control struct between the sequencer and the level units. No dependencies.
package srf_pkg;

    localparam int MAX_STEPS_DEF  = 20;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int FADE_W         = 14;
    localparam int MS_PER_STEP    = 100;
    localparam int FADE_RST       = 1200;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ALT_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 2'd2;

    typedef struct packed {
        logic init;
        logic load_unit;
        logic advance;
    } t_lerp_ctl;

endpackage

### src/srf_serdiv.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, done pulse at the end.
// Uses no package items.
module srf_serdiv #(
    parameter int DW = 19,
    parameter int VW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);
    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_quot;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   n_trial;
    logic [VW:0]   n_diff;
    logic          n_ge;

    always_comb begin
        n_trial = {r_rem, r_quot[DW-1]};
        n_ge    = n_trial >= {1'b0, r_div};
        n_diff  = n_trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_ge ? n_diff[VW-1:0] : n_trial[VW-1:0];
            r_quot <= {r_quot[DW-2:0], n_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

### src/srf_lerp.sv
`timescale 1ns / 1ps
// One level unit: holds start, direction and the per-step quotient and remainder,
// and accumulates start + d*k/steps step by step. Depends on srf_pkg.
module srf_lerp #(
    parameter int W  = 17,
    parameter int SW = 5
) (
    input  logic              i_clk,
    input  srf_pkg::t_lerp_ctl i_ctl,
    input  logic [W-1:0]      i_start,
    input  logic [W-1:0]      i_target,
    input  logic [W-1:0]      i_quot,
    input  logic [SW-1:0]     i_rem,
    input  logic [SW-1:0]     i_steps,
    output logic [W-1:0]      o_mag,
    output logic [W-1:0]      o_next_level
);
    import srf_pkg::*;

    logic [W-1:0]  r_start;
    logic [W-1:0]  r_mag;
    logic          r_neg;
    logic [W-1:0]  r_q;
    logic [SW-1:0] r_r;
    logic [W-1:0]  r_q1;
    logic [SW-1:0] r_r1;
    logic [SW:0]   n_sum;
    logic          n_carry;
    logic [SW:0]   n_wrap;
    logic [W-1:0]  n_q;

    always_comb begin
        n_sum   = {1'b0, r_r} + {1'b0, r_r1};
        n_carry = n_sum >= {1'b0, i_steps};
        n_wrap  = n_sum - {1'b0, i_steps};
        n_q     = r_q + r_q1 + W'(n_carry);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_start <= i_start;
            r_neg   <= i_target < i_start;
            r_mag   <= (i_target < i_start) ? i_start - i_target : i_target - i_start;
            r_q     <= '0;
            r_r     <= '0;
        end else if (i_ctl.advance) begin
            r_q <= n_q;
            r_r <= n_carry ? n_wrap[SW-1:0] : n_sum[SW-1:0];
        end
        if (i_ctl.load_unit) begin
            r_q1 <= i_quot;
            r_r1 <= i_rem;
        end
    end

    assign o_mag        = r_mag;
    assign o_next_level = r_neg ? r_start - n_q : r_start + n_q;
endmodule

### src/stepped_crossfade_ramp_top.sv
`timescale 1ns / 1ps
// Stepped crossfade ramp top: config registers, sequencer, output register.
// Depends on srf_pkg, srf_serdiv, srf_lerp.
//
//  channel   signals                                  direction
//  in        i_in_valid / o_in_stall, i_news_on       event in
//  out       o_out_valid / i_out_stall, levels, step  one transfer per step
//  cfg       i_cfg_valid / o_cfg_ready, index, data   register write
//
// Each event runs serial divisions (DW = max(LEVEL_FRAC_BITS+3, 14)), then one step per cycle
// while the output is not stalled, for 1 to 20 steps at the defaults.
// The shared bit-serial divider sets the setup time; the output register sets the step pace.
// A new event is taken once the last step sits in the output register.
// Reset is synchronous; levels return to main 1.0 and alternate 0.
module stepped_crossfade_ramp_top #(
    parameter int MAX_STEPS       = srf_pkg::MAX_STEPS_DEF,
    parameter int LEVEL_FRAC_BITS = srf_pkg::FRAC_BITS_DEF,
    localparam int MAIN_W = LEVEL_FRAC_BITS + 1,
    localparam int ALT_W  = LEVEL_FRAC_BITS + 3,
    localparam int STEP_W = $clog2(MAX_STEPS + 1),
    localparam int CFG_W  = (ALT_W > srf_pkg::FADE_W) ? ALT_W : srf_pkg::FADE_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_news_on,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [MAIN_W-1:0]            o_main_level,
    output logic [ALT_W-1:0]             o_alternate_level,
    output logic [STEP_W-1:0]            o_step_number,
    output logic                         o_last_step,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [srf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);
    import srf_pkg::*;

    localparam int DIV_VW0 = $clog2(MS_PER_STEP + 1);
    localparam int DIV_VW  = (STEP_W > DIV_VW0) ? STEP_W : DIV_VW0;
    localparam int DIV_DW  = (ALT_W > FADE_W) ? ALT_W : FADE_W;
    localparam logic [MAIN_W-1:0] LEVEL_ONE = MAIN_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [ALT_W-1:0]  ALT_MAX   = ALT_W'(4) << LEVEL_FRAC_BITS;
    localparam logic [ALT_W-1:0]  ALT_RST   =
        ALT_W'(((85 * (2 ** LEVEL_FRAC_BITS)) + 50) / 100);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DSTEP = 3'd1;
    localparam logic [2:0] S_SMAIN = 3'd2;
    localparam logic [2:0] S_DMAIN = 3'd3;
    localparam logic [2:0] S_DALT  = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;

    logic [2:0]        r_state;
    logic [ALT_W-1:0]  r_gain;
    logic [FADE_W-1:0] r_fade_out;
    logic [FADE_W-1:0] r_fade_in;
    logic              r_news;
    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] r_k;
    logic [MAIN_W-1:0] r_main_cur;
    logic [ALT_W-1:0]  r_alt_cur;
    logic              r_out_valid;
    logic [MAIN_W-1:0] r_out_main;
    logic [ALT_W-1:0]  r_out_alt;
    logic [STEP_W-1:0] r_out_step;
    logic              r_out_last;

    logic              in_xfer;
    logic              out_free;
    logic              emit;
    logic              last;
    logic              div_start;
    logic              div_done;
    logic [DIV_DW-1:0] div_dividend;
    logic [DIV_VW-1:0] div_divisor;
    logic [DIV_DW-1:0] div_quot;
    logic [DIV_VW-1:0] div_rem;
    logic [STEP_W-1:0] n_steps;
    logic [ALT_W-1:0]  gain_sat;
    logic [MAIN_W-1:0] main_target;
    logic [ALT_W-1:0]  alt_target;
    logic [MAIN_W-1:0] main_mag;
    logic [ALT_W-1:0]  alt_mag;
    logic [MAIN_W-1:0] main_next;
    logic [ALT_W-1:0]  alt_next;
    t_lerp_ctl         main_ctl;
    t_lerp_ctl         alt_ctl;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_state != S_IDLE;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign emit        = (r_state == S_STEP) && out_free;
    assign last        = (r_k + 1'b1) == r_steps;

    assign gain_sat    = (r_gain > ALT_MAX) ? ALT_MAX : r_gain;
    assign main_target = r_news ? '0 : LEVEL_ONE;
    assign alt_target  = r_news ? gain_sat : '0;

    always_comb begin
        priority if (div_quot == '0) begin
            n_steps = STEP_W'(1);
        end else if (div_quot > DIV_DW'(MAX_STEPS)) begin
            n_steps = STEP_W'(MAX_STEPS);
        end else begin
            n_steps = div_quot[STEP_W-1:0];
        end
    end

    always_comb begin
        div_start = ((r_state == S_IDLE) && in_xfer) || (r_state == S_SMAIN) ||
                    ((r_state == S_DMAIN) && div_done);
        unique case (r_state)
            S_IDLE: begin
                div_dividend = DIV_DW'(i_news_on ? r_fade_out : r_fade_in);
                div_divisor  = DIV_VW'(MS_PER_STEP);
            end
            S_SMAIN: begin
                div_dividend = DIV_DW'(main_mag);
                div_divisor  = DIV_VW'(r_steps);
            end
            default: begin
                div_dividend = DIV_DW'(alt_mag);
                div_divisor  = DIV_VW'(r_steps);
            end
        endcase
    end

    always_comb begin
        main_ctl.init      = (r_state == S_DSTEP) && div_done;
        main_ctl.load_unit = (r_state == S_DMAIN) && div_done;
        main_ctl.advance   = emit;
        alt_ctl.init       = main_ctl.init;
        alt_ctl.load_unit  = (r_state == S_DALT) && div_done;
        alt_ctl.advance    = emit;
    end

    srf_serdiv #(.DW(DIV_DW), .VW(DIV_VW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    srf_lerp #(.W(MAIN_W), .SW(STEP_W)) u_main (
        .i_clk        (i_clk),
        .i_ctl        (main_ctl),
        .i_start      (r_main_cur),
        .i_target     (main_target),
        .i_quot       (div_quot[MAIN_W-1:0]),
        .i_rem        (div_rem[STEP_W-1:0]),
        .i_steps      (r_steps),
        .o_mag        (main_mag),
        .o_next_level (main_next)
    );

    srf_lerp #(.W(ALT_W), .SW(STEP_W)) u_alt (
        .i_clk        (i_clk),
        .i_ctl        (alt_ctl),
        .i_start      (r_alt_cur),
        .i_target     (alt_target),
        .i_quot       (div_quot[ALT_W-1:0]),
        .i_rem        (div_rem[STEP_W-1:0]),
        .i_steps      (r_steps),
        .o_mag        (alt_mag),
        .o_next_level (alt_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= ALT_RST;
            r_fade_out <= FADE_W'(FADE_RST);
            r_fade_in  <= FADE_W'(FADE_RST);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ALT_GAIN: r_gain     <= i_cfg_data[ALT_W-1:0];
                REG_FADE_OUT: r_fade_out <= i_cfg_data[FADE_W-1:0];
                REG_FADE_IN:  r_fade_in  <= i_cfg_data[FADE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_main_cur  <= LEVEL_ONE;
            r_alt_cur   <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
                r_main_cur  <= main_next;
                r_alt_cur   <= alt_next;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE:  if (in_xfer) begin
                    r_state <= S_DSTEP;
                end
                S_DSTEP: if (div_done) begin
                    r_state <= S_SMAIN;
                end
                S_SMAIN: r_state <= S_DMAIN;
                S_DMAIN: if (div_done) begin
                    r_state <= S_DALT;
                end
                S_DALT:  if (div_done) begin
                    r_state <= S_STEP;
                end
                S_STEP:  if (emit && last) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_news <= i_news_on;
        end
        if ((r_state == S_DSTEP) && div_done) begin
            r_steps <= n_steps;
            r_k     <= '0;
        end else if (emit) begin
            r_k <= r_k + 1'b1;
        end
        if (emit) begin
            r_out_main <= main_next;
            r_out_alt  <= alt_next;
            r_out_step <= r_k + 1'b1;
            r_out_last <= last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_main_level      = r_out_main;
    assign o_alternate_level = r_out_alt;
    assign o_step_number     = r_out_step;
    assign o_last_step       = r_out_last;
endmodule

### src/srf_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the stepped crossfade ramp, bound to the top level.
// Depends on srf_pkg and stepped_crossfade_ramp_top.
module srf_checker #(
    parameter int MAX_STEPS       = srf_pkg::MAX_STEPS_DEF,
    parameter int LEVEL_FRAC_BITS = srf_pkg::FRAC_BITS_DEF,
    localparam int MAIN_W = LEVEL_FRAC_BITS + 1,
    localparam int ALT_W  = LEVEL_FRAC_BITS + 3,
    localparam int STEP_W = $clog2(MAX_STEPS + 1)
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [MAIN_W-1:0] o_main_level,
    input logic [ALT_W-1:0]  o_alternate_level,
    input logic [STEP_W-1:0] o_step_number,
    input logic              o_last_step
);
    localparam logic [MAIN_W-1:0] LEVEL_ONE = MAIN_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [ALT_W-1:0]  ALT_MAX   = ALT_W'(4) << LEVEL_FRAC_BITS;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_main_level) &&
        $stable(o_alternate_level) && $stable(o_step_number) && $stable(o_last_step))
        else $error("output transfer changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("event accepted without going busy");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_step_number != '0 && o_step_number <= STEP_W'(MAX_STEPS))
        else $error("step number out of range");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_main_level <= LEVEL_ONE && o_alternate_level <= ALT_MAX)
        else $error("level beyond its limit");
endmodule

bind stepped_crossfade_ramp_top srf_checker #(
    .MAX_STEPS       (MAX_STEPS),
    .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
) u_srf_checker (.*);
